>>> hdl/pol_pkg.sv
// Package for the positional ordered list: sizes, codes and shared types.
// No dependencies; every other file of the block but pol_if imports it.
`default_nettype none

package pol_pkg;

  localparam int CAPACITY = 16;
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int LEVELS   = $clog2(CAPACITY);
  localparam int PAD      = 1 << LEVELS;
  localparam int CMP_W    = ((FILL_W > 5) ? FILL_W : 5) + 1;
  localparam int LVL_W    = $clog2(LEVELS + 1);

  typedef logic signed [31:0]             word_t;
  typedef logic [FILL_W-1:0]              fill_t;
  typedef logic [CMP_W-1:0]               cidx_t;
  typedef logic [CAPACITY-1:0][31:0]      entry_vec_t;

  typedef enum logic [2:0] {
    K_INS_AT   = 3'd0,
    K_DEL_AT   = 3'd1,
    K_PUSH_FRT = 3'd2,
    K_PUSH_BCK = 3'd3,
    K_POP_FRT  = 3'd4,
    K_POP_BCK  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_REDUCE,
    S_FINISH
  } state_e;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic  ins;
    logic  del;
    cidx_t idx;
    word_t value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/pol_if.sv
// Handshake channels of the positional ordered list: command in, result out.
// Does not depend on pol_pkg.
`default_nettype none

interface pol_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [4:0]        position;
  logic signed [31:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface pol_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [4:0]         count;
  logic signed [31:0] smallest;
  logic signed [31:0] largest;
  logic               is_empty;

  modport source (output valid, status, count, smallest, largest, is_empty, input ready);
  modport sink   (input valid, status, count, smallest, largest, is_empty, output ready);
endinterface

`default_nettype wire

>>> hdl/positional_ordered_list.sv
// Positional ordered list: a chain of CAPACITY cells with insert/delete shifting.
// A beat is taken only in S_IDLE, then the block walks S_LOAD, S_REDUCE and S_FINISH;
// no new beat is accepted until the result has gone to the output register.
// Reset (rst_n, synchronous, active low) empties the list; cell contents stay
// undefined until written. Depends on pol_pkg, pol_if, pol_cell, pol_minmax.
`default_nettype none

module positional_ordered_list import pol_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pol_in_if.sink     in_ch,
  pol_out_if.source  out_ch
);

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  state_e            state_r, state_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  fill_t             fill_r, fill_nxt;
  status_e           st_r, st_nxt;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [4:0]        out_count_r;
  word_t             out_small_r;
  word_t             out_large_r;
  logic              out_empty_r;

  logic              in_beat;
  logic              mm_load;
  logic              mm_step;
  logic              out_load;

  cell_ctrl_t        ctrl;
  entry_vec_t        entry_vec;
  word_t             mm_small;
  word_t             mm_large;
  logic              mm_empty;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_beat     = in_ch.valid & in_ch.ready;

  // ---------------------------------------------------------------------
  // Command decode: check the position against the fill level, pick the
  // shift index and direction for the cell chain, and form the status.
  // ---------------------------------------------------------------------
  cidx_t pos_x;
  cidx_t fill_x;
  logic  full;
  logic  ins_ok;
  logic  del_ok;

  always_comb begin
    pos_x    = CMP_W'(in_ch.position);
    fill_x   = CMP_W'(fill_r);
    full     = (fill_r == FILL_W'(CAPACITY));
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    st_nxt   = ST_OK;
    ctrl.idx = '0;
    unique case (in_ch.kind)
      K_INS_AT: begin
        if ((pos_x == '0) || (pos_x > fill_x + CMP_W'(1))) begin
          st_nxt = ST_BADPOS;
        end else if (full) begin
          st_nxt = ST_FULL;
        end else begin
          ins_ok   = 1'b1;
          ctrl.idx = pos_x - CMP_W'(1);
        end
      end
      K_DEL_AT: begin
        if ((pos_x == '0) || (pos_x > fill_x)) begin
          st_nxt = ST_BADPOS;
        end else begin
          del_ok   = 1'b1;
          ctrl.idx = pos_x - CMP_W'(1);
        end
      end
      K_PUSH_FRT: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      K_PUSH_BCK: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          ins_ok   = 1'b1;
          ctrl.idx = fill_x;
        end
      end
      K_POP_FRT: begin
        if (fill_r == '0) begin
          st_nxt = ST_EMPTY;
        end else begin
          del_ok = 1'b1;
        end
      end
      K_POP_BCK: begin
        if (fill_r == '0) begin
          st_nxt = ST_EMPTY;
        end else begin
          del_ok   = 1'b1;
          ctrl.idx = fill_x - CMP_W'(1);
        end
      end
      default: begin
        // unused kinds: no operation, status ok
      end
    endcase
    ctrl.ins   = in_beat & ins_ok;
    ctrl.del   = in_beat & del_ok;
    ctrl.value = in_ch.value;

    fill_nxt = fill_r;
    if (ctrl.ins) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (ctrl.del) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Cell chain: every cell sees the same command and its two neighbors.
  // Insert shifts toward the back, delete pulls from the back.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w;
    word_t right_w;
    word_t entry_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = word_t'(entry_vec[i-1]);
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = word_t'(entry_vec[i+1]);
    end

    pol_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .cell_idx    (CMP_W'(i)),
      .left_entry  (left_w),
      .right_entry (right_w),
      .entry_r     (entry_w)
    );

    assign entry_vec[i] = entry_w;
  end

  // ---------------------------------------------------------------------
  // Min/max over the valid cells, LEVELS halving steps after a load.
  // ---------------------------------------------------------------------
  pol_minmax u_minmax (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (mm_load),
    .step     (mm_step),
    .entries  (entry_vec),
    .fill     (fill_r),
    .smallest (mm_small),
    .largest  (mm_large),
    .is_empty (mm_empty)
  );

  // ---------------------------------------------------------------------
  // Sequencer: accept, load snapshot, reduce, then hand to the output
  // register once it is free (or being taken this cycle).
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    mm_load   = 1'b0;
    mm_step   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        mm_load   = 1'b1;
        lvl_nxt   = LVL_W'(LEVELS);
        state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        mm_step = 1'b1;
        lvl_nxt = lvl_r - LVL_W'(1);
        if (lvl_r == LVL_W'(1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lvl_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      fill_r  <= fill_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold status from the accept, result from the reduction.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      st_r <= st_nxt;
    end
    if (out_load) begin
      out_status_r <= st_r;
      out_count_r  <= 5'(fill_r);
      out_small_r  <= mm_small;
      out_large_r  <= mm_large;
      out_empty_r  <= mm_empty;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.count    = out_count_r;
  assign out_ch.smallest = out_small_r;
  assign out_ch.largest  = out_large_r;
  assign out_ch.is_empty = out_empty_r;

endmodule

`default_nettype wire

>>> hdl/pol_cell.sv
// One storage cell of the list chain: holds one entry, shifts with neighbors.
// Depends on pol_pkg.
`default_nettype none

module pol_cell import pol_pkg::*; (
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire cidx_t      cell_idx,
  input  wire word_t      left_entry,
  input  wire word_t      right_entry,
  output word_t           entry_r
);

  word_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (cell_idx > ctrl.idx) begin
        entry_nxt = left_entry;
      end else if (cell_idx == ctrl.idx) begin
        entry_nxt = ctrl.value;
      end
    end else if (ctrl.del && (cell_idx >= ctrl.idx)) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/pol_minmax.sv
// Min/max reduction over the cell chain: load a snapshot, halve it each step.
// Depends on pol_pkg.
`default_nettype none

module pol_minmax import pol_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire logic       step,
  input  wire entry_vec_t entries,
  input  wire fill_t      fill,
  output word_t           smallest,
  output word_t           largest,
  output logic            is_empty
);

  word_t           lo_r  [PAD];
  word_t           hi_r  [PAD];
  word_t           lo_nxt[PAD];
  word_t           hi_nxt[PAD];
  logic [PAD-1:0]  vld_r;
  logic [PAD-1:0]  vld_nxt;

  always_comb begin
    for (int k = 0; k < PAD; k++) begin
      lo_nxt[k]  = lo_r[k];
      hi_nxt[k]  = hi_r[k];
      vld_nxt[k] = vld_r[k];
    end
    if (load) begin
      for (int k = 0; k < PAD; k++) begin
        if (k < CAPACITY) begin
          lo_nxt[k]  = word_t'(entries[k]);
          hi_nxt[k]  = word_t'(entries[k]);
          vld_nxt[k] = (FILL_W'(k) < fill);
        end else begin
          vld_nxt[k] = 1'b0;
        end
      end
    end else if (step) begin
      // pair neighbors, keep the lower half
      for (int k = 0; k < PAD / 2; k++) begin
        if (vld_r[2*k] && vld_r[2*k+1]) begin
          lo_nxt[k] = (lo_r[2*k+1] < lo_r[2*k]) ? lo_r[2*k+1] : lo_r[2*k];
          hi_nxt[k] = (hi_r[2*k+1] > hi_r[2*k]) ? hi_r[2*k+1] : hi_r[2*k];
        end else if (vld_r[2*k+1]) begin
          lo_nxt[k] = lo_r[2*k+1];
          hi_nxt[k] = hi_r[2*k+1];
        end else begin
          lo_nxt[k] = lo_r[2*k];
          hi_nxt[k] = hi_r[2*k];
        end
        vld_nxt[k] = vld_r[2*k] | vld_r[2*k+1];
      end
      for (int k = PAD / 2; k < PAD; k++) begin
        vld_nxt[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
    for (int k = 0; k < PAD; k++) begin
      lo_r[k] <= lo_nxt[k];
      hi_r[k] <= hi_nxt[k];
    end
  end

  assign is_empty = ~vld_r[0];
  assign smallest = vld_r[0] ? lo_r[0] : '0;
  assign largest  = vld_r[0] ? hi_r[0] : '0;

endmodule

`default_nettype wire

>>> tb/positional_ordered_list_tb.sv
// Self-checking bench for positional_ordered_list: directed table, then random command streams.
// Needs pol_pkg, pol_if and the block's RTL only; expected results come from a shadow list or fixed rows.

module positional_ordered_list_tb;
  import pol_pkg::*;

  // Run shape: random beats after the directed table, where the idle-free tail starts,
  // when the receiver backs up the block and when the sender drains everything.
  localparam int N_RANDOM    = 900;
  localparam int CALM_FROM   = 750;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 150;
  localparam int DRAIN_AT    = 600;
  localparam int TAIL        = 20;
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_REPORT  = 10;

  localparam word_t W_MIN = 32'sh8000_0000;
  localparam word_t W_MAX = 32'sh7fff_ffff;

  // One result beat as the block reports it.
  typedef struct packed {
    status_e    status;
    logic [4:0] count;
    word_t      smallest;
    word_t      largest;
    logic       is_empty;
  } outcome_t;

  // One row of the directed table; rows with has_fixed carry a hand-typed result.
  typedef struct {
    kind_e      kind;
    logic [4:0] pos;
    word_t      value;
    int         reps;
    bit         has_fixed;
    outcome_t   fixed;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  pol_in_if  in_ch ();
  pol_out_if out_ch ();

  positional_ordered_list i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the list contents, front at index 0, and the results still owed.
  word_t    shadow_list[$];
  outcome_t owed_q[$];

  int cmd_cnt   = 0;
  int res_cnt   = 0;
  int fault_cnt = 0;
  int peak_fill = 0;
  int stall_cycles = 0;
  int status_hits[4] = '{0, 0, 0, 0};
  bit calm      = 1'b0;
  bit hold_done = 1'b0;

  // ---------------------------------------------------------------------------
  // Shadow list: apply one command and return the result the block must give.
  // ---------------------------------------------------------------------------
  function automatic outcome_t apply_cmd(kind_e k, logic [4:0] p, word_t v);
    outcome_t r;
    int n;
    word_t lo, hi;
    r = '0;
    r.status = ST_OK;
    n = shadow_list.size();
    case (k)
      K_INS_AT: begin
        // position range is checked before capacity
        if (p == 0 || int'(p) > n + 1) r.status = ST_BADPOS;
        else if (n >= CAPACITY) r.status = ST_FULL;
        else shadow_list.insert(int'(p) - 1, v);
      end
      K_DEL_AT: begin
        if (p == 0 || int'(p) > n) r.status = ST_BADPOS;
        else shadow_list.delete(int'(p) - 1);
      end
      K_PUSH_FRT: begin
        if (n >= CAPACITY) r.status = ST_FULL;
        else shadow_list.push_front(v);
      end
      K_PUSH_BCK: begin
        if (n >= CAPACITY) r.status = ST_FULL;
        else shadow_list.push_back(v);
      end
      K_POP_FRT: begin
        if (n == 0) r.status = ST_EMPTY;
        else void'(shadow_list.pop_front());
      end
      K_POP_BCK: begin
        if (n == 0) r.status = ST_EMPTY;
        else void'(shadow_list.pop_back());
      end
      default: ;
    endcase
    n  = shadow_list.size();
    lo = '0;
    hi = '0;
    if (n > 0) begin
      lo = shadow_list[0];
      hi = shadow_list[0];
      foreach (shadow_list[j]) begin
        if (shadow_list[j] < lo) lo = shadow_list[j];
        if (shadow_list[j] > hi) hi = shadow_list[j];
      end
    end
    r.count    = 5'(n);
    r.smallest = lo;
    r.largest  = hi;
    r.is_empty = (n == 0);
    if (n > peak_fill) peak_fill = n;
    return r;
  endfunction

  function automatic string show(outcome_t r);
    return $sformatf("status %0d count %0d min %0d max %0d empty %0b",
                     r.status, r.count, r.smallest, r.largest, r.is_empty);
  endfunction

  function automatic void note_fault(string msg);
    fault_cnt++;
    if (fault_cnt <= MAX_REPORT) $display("[%0t] MISMATCH %s", $realtime, msg);
  endfunction

  // Compare one result beat with the oldest owed result, field by field.
  function automatic void check_result(outcome_t got);
    outcome_t want;
    if (owed_q.size() == 0) begin
      note_fault($sformatf("result with nothing owed: %s", show(got)));
      return;
    end
    want = owed_q.pop_front();
    if (got.status !== want.status || got.count !== want.count ||
        got.smallest !== want.smallest || got.largest !== want.largest ||
        got.is_empty !== want.is_empty)
      note_fault($sformatf("result %0d\n  expected %s\n  actual   %s",
                           res_cnt, show(want), show(got)));
  endfunction

  // Mostly boundary words and near-duplicates, so min and max tracking gets exercised.
  function automatic word_t pick_value();
    case ($urandom_range(0, 9))
      0:       return W_MIN;
      1:       return W_MAX;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return word_t'($urandom_range(0, 16)) - 32'sd8;
      default: return word_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side: hold a beat on the input until it is taken, then book its result.
  // ---------------------------------------------------------------------------
  task automatic offer(kind_e k, logic [4:0] p, word_t v, bit has_fixed, outcome_t fixed);
    outcome_t want;
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= k;
    in_ch.position <= p;
    in_ch.value    <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    want = apply_cmd(k, p, v);
    owed_q.push_back(has_fixed ? fixed : want);
    cmd_cnt++;
  endtask

  task automatic rest_in(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Random part: the list drifts between growing and shrinking phases so it
  // regularly reaches both full and empty; a small share of beats is pure noise.
  task automatic run_random();
    kind_e k;
    logic [4:0] p;
    word_t v;
    int n, roll, i;
    bit grow;
    grow = 1'b1;
    for (i = 0; i < N_RANDOM; i++) begin
      n = shadow_list.size();
      if (n == CAPACITY && $urandom_range(0, 3) == 0) grow = 1'b0;
      else if (n == 0 && $urandom_range(0, 2) == 0) grow = 1'b1;
      else if ($urandom_range(0, 49) == 0) grow = ~grow;

      roll = $urandom_range(0, 99);
      p    = 5'($urandom_range(0, 31));
      if (roll < 8) begin
        k = kind_e'($urandom_range(0, 5));
      end else if (grow ? (roll < 75) : (roll >= 75)) begin
        case ($urandom_range(0, 3))
          0, 1:    k = K_INS_AT;
          2:       k = K_PUSH_FRT;
          default: k = K_PUSH_BCK;
        endcase
        if (k == K_INS_AT) p = 5'($urandom_range(1, n + 1));
      end else begin
        case ($urandom_range(0, 3))
          0, 1:    k = K_DEL_AT;
          2:       k = K_POP_FRT;
          default: k = K_POP_BCK;
        endcase
        if (k == K_DEL_AT && n > 0) p = 5'($urandom_range(1, n));
      end
      v = pick_value();

      // Pause once until every owed result is back, so the block runs dry.
      if (i == DRAIN_AT) begin
        rest_in(1);
        while (owed_q.size() != 0) @(posedge clk);
      end
      calm = (i >= CALM_FROM);

      offer(k, p, v, 1'b0, '0);

      // Gaps come in bursts, and every 64 beats a stretch runs without any.
      if (!calm && (i % 64) < 40 && $urandom_range(0, 4) == 0)
        rest_in($urandom_range(1, 13));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall bursts in lazy segments, one long hold-off that
  // backs the block up into its input, and no stalls during the tail.
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    int seg;
    bit lazy;
    seg  = 0;
    lazy = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!hold_done && cmd_cnt >= HOLD_AT) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && lazy && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
      if (seg == 0) begin
        seg  = $urandom_range(20, 80);
        lazy = $urandom_range(0, 1);
      end else begin
        seg--;
      end
    end
  end

  // Check every result beat as it is taken.
  always @(posedge clk) begin : watch_out
    outcome_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status   = status_e'(out_ch.status);
      got.count    = out_ch.count;
      got.smallest = out_ch.smallest;
      got.largest  = out_ch.largest;
      got.is_empty = out_ch.is_empty;
      res_cnt++;
      status_hits[out_ch.status]++;
      check_result(got);
    end
  end

  // Watchdog: count cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] no beat moved for %0d cycles, %0d results owed",
                 $realtime, STALL_LIMIT, owed_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random part, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    step_row_t plan[25];
    int r, k;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= K_INS_AT;
    in_ch.position <= '0;
    in_ch.value    <= '0;

    // Empty list errors, both value extremes, out-of-range positions, position
    // ignored by push and pop, fill to capacity and the full cases, then empty again.
    plan = '{
      '{K_POP_FRT,  5'd0,  32'sd0,   1,  1'b1, '{ST_EMPTY,  5'd0,  32'sd0, 32'sd0, 1'b1}},
      '{K_POP_BCK,  5'd0,  32'sd0,   1,  1'b1, '{ST_EMPTY,  5'd0,  32'sd0, 32'sd0, 1'b1}},
      '{K_DEL_AT,   5'd1,  32'sd0,   1,  1'b1, '{ST_BADPOS, 5'd0,  32'sd0, 32'sd0, 1'b1}},
      '{K_INS_AT,   5'd0,  32'sd5,   1,  1'b1, '{ST_BADPOS, 5'd0,  32'sd0, 32'sd0, 1'b1}},
      '{K_INS_AT,   5'd2,  32'sd5,   1,  1'b1, '{ST_BADPOS, 5'd0,  32'sd0, 32'sd0, 1'b1}},
      '{K_INS_AT,   5'd1,  W_MAX,    1,  1'b1, '{ST_OK,     5'd1,  W_MAX,  W_MAX,  1'b0}},
      '{K_PUSH_FRT, 5'd0,  W_MIN,    1,  1'b1, '{ST_OK,     5'd2,  W_MIN,  W_MAX,  1'b0}},
      '{K_PUSH_BCK, 5'd0,  32'sd0,   1,  1'b0, '0},
      '{K_INS_AT,   5'd31, 32'sd1,   1,  1'b1, '{ST_BADPOS, 5'd3,  W_MIN,  W_MAX,  1'b0}},
      '{K_DEL_AT,   5'd4,  32'sd0,   1,  1'b1, '{ST_BADPOS, 5'd3,  W_MIN,  W_MAX,  1'b0}},
      '{K_DEL_AT,   5'd0,  32'sd0,   1,  1'b1, '{ST_BADPOS, 5'd3,  W_MIN,  W_MAX,  1'b0}},
      '{K_INS_AT,   5'd4,  -32'sd1,  1,  1'b0, '0},
      '{K_PUSH_FRT, 5'd31, 32'sd3,   1,  1'b0, '0},
      '{K_DEL_AT,   5'd2,  32'sd0,   1,  1'b0, '0},
      '{K_POP_FRT,  5'd31, 32'sd0,   1,  1'b0, '0},
      '{K_POP_BCK,  5'd0,  32'sd0,   1,  1'b0, '0},
      '{K_PUSH_BCK, 5'd0,  32'sd100, 14, 1'b0, '0},
      '{K_PUSH_BCK, 5'd0,  32'sd9,   1,  1'b1, '{ST_FULL,   5'd16, 32'sd0, W_MAX,  1'b0}},
      '{K_INS_AT,   5'd17, 32'sd9,   1,  1'b1, '{ST_FULL,   5'd16, 32'sd0, W_MAX,  1'b0}},
      '{K_INS_AT,   5'd18, 32'sd9,   1,  1'b1, '{ST_BADPOS, 5'd16, 32'sd0, W_MAX,  1'b0}},
      '{K_PUSH_FRT, 5'd0,  32'sd9,   1,  1'b1, '{ST_FULL,   5'd16, 32'sd0, W_MAX,  1'b0}},
      '{K_DEL_AT,   5'd16, 32'sd0,   1,  1'b0, '0},
      '{K_POP_BCK,  5'd0,  32'sd0,   15, 1'b0, '0},
      '{K_POP_BCK,  5'd0,  32'sd0,   1,  1'b1, '{ST_EMPTY,  5'd0,  32'sd0, 32'sd0, 1'b1}},
      '{K_POP_FRT,  5'd31, 32'sd0,   1,  1'b1, '{ST_EMPTY,  5'd0,  32'sd0, 32'sd0, 1'b1}}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the table back to back; repeated rows step the value so entries differ.
    for (r = 0; r < 25; r++)
      for (k = 0; k < plan[r].reps; k++)
        offer(plan[r].kind, plan[r].pos, plan[r].value + word_t'(k),
              plan[r].has_fixed, plan[r].fixed);

    run_random();

    // Drop valid, wait for the last results, then let the pipeline settle.
    in_ch.valid <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("Ran %0d commands, %0d results, list peaked at %0d of %0d entries.",
             cmd_cnt, res_cnt, peak_fill, CAPACITY);
    $display("Status seen: ok %0d, bad position %0d, empty %0d, full %0d; %0d mismatches.",
             status_hits[ST_OK], status_hits[ST_BADPOS], status_hits[ST_EMPTY],
             status_hits[ST_FULL], fault_cnt);
    if (fault_cnt == 0 && owed_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
